FILE: src/bavg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block average downsampler package
// Shared sizes, payload types and helper functions for the tile averaging
// datapath.
// ----------------------------------------------------------------------------
package bavg_pkg;

    // Sizing constants.
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_FACTOR = 16;
    localparam int PIXEL_BITS = 16;

    // Fixed field widths of the channels.
    localparam int PIXEL_W    = 16;
    localparam int MEAN_W     = 24;
    localparam int TILE_W     = 9;
    localparam int FACTOR_W   = 5;
    localparam int DIM_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // Internal widths.
    localparam int SUM_W      = 24;
    localparam int FRAC_W     = 8;
    localparam int QUOT_W     = SUM_W + FRAC_W;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIMC_W     = COL_W + 1;
    localparam int RIT_W      = $clog2(MAX_FACTOR);
    localparam int FW         = $clog2(MAX_FACTOR + 1);
    localparam int CNT_W      = 2 * FW;

    // Job queue between the accumulator front and the divider back.
    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

    localparam logic [PIXEL_W-1:0] PIXEL_MASK = (PIXEL_BITS >= PIXEL_W) ?
        {PIXEL_W{1'b1}} : PIXEL_W'((64'd1 << PIXEL_BITS) - 64'd1);

    // One finished tile waiting for its mean.
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [FW-1:0]     ncols;
        logic [FW-1:0]     nrows;
        logic [TILE_W-1:0] tile_col;
        logic [TILE_W-1:0] tile_row;
        logic              last_tile;
        logic              size_error;
    } bavg_job_t;

    typedef struct packed {
        logic                  empty;
        logic [JOBQ_CNT_W-1:0] count;
    } bavg_fifo_stat_t;

    // Zero means one; anything above the maximum saturates.
    function automatic logic [FW-1:0] clamp_factor(logic [FACTOR_W-1:0] v);
        logic [FW-1:0] r;
        if (v == '0)
            r = FW'(1);
        else if (int'(v) > MAX_FACTOR)
            r = FW'(MAX_FACTOR);
        else
            r = FW'(v);
        return r;
    endfunction

    function automatic logic [DIMC_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
        logic [DIMC_W-1:0] r;
        if (v == '0)
            r = DIMC_W'(1);
        else if (int'(v) > MAX_WIDTH)
            r = DIMC_W'(MAX_WIDTH);
        else
            r = DIMC_W'(v);
        return r;
    endfunction

endpackage

FILE: src/bavg_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel channel interface
// Valid/ready channel that carries one pixel per item.
// ----------------------------------------------------------------------------
interface bavg_pixel_if
    import bavg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

FILE: src/bavg_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel that carries one tile mean per item.
// ----------------------------------------------------------------------------
interface bavg_result_if
    import bavg_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MEAN_W-1:0] mean_value;
    logic [TILE_W-1:0] tile_col;
    logic [TILE_W-1:0] tile_row;
    logic              last_tile;
    logic              size_error;

    modport source (output valid, output mean_value, output tile_col, output tile_row,
                    output last_tile, output size_error, input ready);
    modport sink   (input valid, input mean_value, input tile_col, input tile_row,
                    input last_tile, input size_error, output ready);
endinterface

FILE: src/bavg_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write interface
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bavg_cfg_if
    import bavg_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/bavg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block average front end
// Holds the registers, tracks the raster position, accumulates tile sums in
// the column memory and queues a job for every finished tile.
// ----------------------------------------------------------------------------
module bavg_front
    import bavg_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    bavg_pixel_if.sink      pixels,
    bavg_cfg_if.sink        cfg,
    input  bavg_fifo_stat_t q_stat,
    output logic            push,
    output bavg_job_t       push_job
);

    localparam int MOD_CNT_W = $clog2(DIMC_W);

    // Registers.
    logic [FACTOR_W-1:0] factor_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;

    // Raster position.
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] row_reg, row_next;
    logic [RIT_W-1:0] cit_reg, cit_next;
    logic [RIT_W-1:0] rit_reg, rit_next;
    logic [COL_W-1:0] tc_reg, tc_next;
    logic [COL_W-1:0] tr_reg, tr_next;

    // Size check.
    logic                 busy_reg;
    logic [MOD_CNT_W-1:0] mcnt_reg;
    logic [FW-1:0]        rem_w_reg, rem_w_next;
    logic [FW-1:0]        rem_h_reg, rem_h_next;
    logic                 size_err_reg;

    // Second stage.
    logic               s2_valid_reg;
    logic [PIXEL_W-1:0] s2_px_reg;
    logic               s2_first_reg;
    logic               s2_done_reg;
    logic [COL_W-1:0]   s2_idx_reg;
    logic [FW-1:0]      s2_ncols_reg;
    logic [FW-1:0]      s2_nrows_reg;
    logic [COL_W-1:0]   s2_tr_reg;
    logic               s2_last_reg;
    logic               byp_reg;
    logic [SUM_W-1:0]   byp_data_reg;
    logic [SUM_W-1:0]   rd_reg;

    logic [SUM_W-1:0] tile_mem [MAX_WIDTH];

    logic [FW-1:0]        f_cl, f_m1_full;
    logic [DIMC_W-1:0]    w_cl, h_cl, w_m1_full, h_m1_full;
    logic [RIT_W-1:0]     f_m1;
    logic [COL_W-1:0]     w_m1, h_m1;
    logic                 cfg_wr, cfg_restart, accept, in_ready;
    logic                 at_col_end, at_row_end, last_col, last_row;
    logic [JOBQ_CNT_W:0]  q_need;
    logic [SUM_W-1:0]     sum_base, sum_new;
    logic [MOD_CNT_W-1:0] bit_idx;

    function automatic logic [FW-1:0] mod_step(logic [FW-1:0] r, logic b, logic [FW-1:0] d);
        logic [FW:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
            t = t - {1'b0, d};
        return FW'(t);
    endfunction

    assign f_cl      = clamp_factor(factor_reg);
    assign w_cl      = clamp_dim(width_reg);
    assign h_cl      = clamp_dim(height_reg);
    assign f_m1_full = f_cl - FW'(1);
    assign w_m1_full = w_cl - DIMC_W'(1);
    assign h_m1_full = h_cl - DIMC_W'(1);
    assign f_m1      = RIT_W'(f_m1_full);
    assign w_m1      = COL_W'(w_m1_full);
    assign h_m1      = COL_W'(h_m1_full);

    assign cfg.ready   = 1'b1;
    assign cfg_wr      = cfg.valid && cfg.ready;
    assign cfg_restart = cfg_wr && (cfg.index == REG_FACTOR || cfg.index == REG_WIDTH ||
                                    cfg.index == REG_HEIGHT);

    // The stage-2 item may still push, so leave a slot for it.
    assign q_need   = {1'b0, q_stat.count} + {{JOBQ_CNT_W{1'b0}}, push};
    assign in_ready = !busy_reg && (q_need < (JOBQ_CNT_W + 1)'(JOBQ_DEPTH));
    assign pixels.ready = in_ready;
    assign accept   = pixels.valid && in_ready;

    assign last_col   = (col_reg == w_m1);
    assign last_row   = (row_reg == h_m1);
    assign at_col_end = (cit_reg == f_m1) || last_col;
    assign at_row_end = (rit_reg == f_m1) || last_row;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        cit_next = cit_reg;
        rit_next = rit_reg;
        tc_next  = tc_reg;
        tr_next  = tr_reg;
        if (cfg_restart)
        begin
            col_next = '0;
            row_next = '0;
            cit_next = '0;
            rit_next = '0;
            tc_next  = '0;
            tr_next  = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                cit_next = '0;
                tc_next  = '0;
                if (last_row)
                begin
                    row_next = '0;
                    rit_next = '0;
                    tr_next  = '0;
                end
                else
                begin
                    row_next = row_reg + COL_W'(1);
                    if (rit_reg == f_m1)
                    begin
                        rit_next = '0;
                        tr_next  = tr_reg + COL_W'(1);
                    end
                    else
                    begin
                        rit_next = rit_reg + RIT_W'(1);
                    end
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
                if (cit_reg == f_m1)
                begin
                    cit_next = '0;
                    tc_next  = tc_reg + COL_W'(1);
                end
                else
                begin
                    cit_next = cit_reg + RIT_W'(1);
                end
            end
        end
    end

    // Remainders of width and height by the factor, one bit per cycle, MSB first.
    assign bit_idx    = MOD_CNT_W'(DIMC_W - 1) - mcnt_reg;
    assign rem_w_next = mod_step(rem_w_reg, w_cl[bit_idx], f_cl);
    assign rem_h_next = mod_step(rem_h_reg, h_cl[bit_idx], f_cl);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg   <= FACTOR_W'(1);
            width_reg    <= DIM_W'(512);
            height_reg   <= DIM_W'(512);
            col_reg      <= '0;
            row_reg      <= '0;
            cit_reg      <= '0;
            rit_reg      <= '0;
            tc_reg       <= '0;
            tr_reg       <= '0;
            busy_reg     <= 1'b0;
            mcnt_reg     <= '0;
            rem_w_reg    <= '0;
            rem_h_reg    <= '0;
            size_err_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg.index)
                    REG_FACTOR: factor_reg <= cfg.data[FACTOR_W-1:0];
                    REG_WIDTH:  width_reg  <= cfg.data[DIM_W-1:0];
                    REG_HEIGHT: height_reg <= cfg.data[DIM_W-1:0];
                    default:    ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
            cit_reg <= cit_next;
            rit_reg <= rit_next;
            tc_reg  <= tc_next;
            tr_reg  <= tr_next;

            if (cfg_restart)
            begin
                busy_reg  <= 1'b1;
                mcnt_reg  <= '0;
                rem_w_reg <= '0;
                rem_h_reg <= '0;
            end
            else if (busy_reg)
            begin
                rem_w_reg <= rem_w_next;
                rem_h_reg <= rem_h_next;
                mcnt_reg  <= mcnt_reg + MOD_CNT_W'(1);
                if (mcnt_reg == MOD_CNT_W'(DIMC_W - 1))
                begin
                    busy_reg     <= 1'b0;
                    size_err_reg <= (rem_w_next != '0) || (rem_h_next != '0);
                end
            end

            s2_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_px_reg    <= pixels.pixel & PIXEL_MASK;
            s2_first_reg <= (rit_reg == '0) && (cit_reg == '0);
            s2_done_reg  <= at_col_end && at_row_end;
            s2_idx_reg   <= tc_reg;
            s2_ncols_reg <= FW'(cit_reg) + FW'(1);
            s2_nrows_reg <= FW'(rit_reg) + FW'(1);
            s2_tr_reg    <= tr_reg;
            s2_last_reg  <= last_col && last_row;
            // The write of the item ahead lands on this same edge.
            byp_reg      <= s2_valid_reg && (s2_idx_reg == tc_reg);
            byp_data_reg <= sum_new;
        end
    end

    // Tile column accumulators.
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
            tile_mem[s2_idx_reg] <= sum_new;
        if (accept)
            rd_reg <= tile_mem[tc_reg];
    end

    assign sum_base = byp_reg ? byp_data_reg : rd_reg;
    assign sum_new  = (s2_first_reg ? '0 : sum_base) + SUM_W'(s2_px_reg);

    assign push                = s2_valid_reg && s2_done_reg;
    assign push_job.sum        = sum_new;
    assign push_job.ncols      = s2_ncols_reg;
    assign push_job.nrows      = s2_nrows_reg;
    assign push_job.tile_col   = TILE_W'(s2_idx_reg);
    assign push_job.tile_row   = TILE_W'(s2_tr_reg);
    assign push_job.last_tile  = s2_last_reg;
    assign push_job.size_error = size_err_reg;

endmodule

FILE: src/bavg_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block average job queue
// Short first-in first-out queue of finished tiles between front and back.
// ----------------------------------------------------------------------------
module bavg_job_fifo
    import bavg_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bavg_job_t       push_job,
    input  logic            pop,
    output bavg_job_t       pop_job,
    output bavg_fifo_stat_t stat
);

    bavg_job_t             slots_reg [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] wr_ptr_reg;
    logic [JOBQ_PTR_W-1:0] rd_ptr_reg;
    logic [JOBQ_CNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + JOBQ_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + JOBQ_PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + JOBQ_CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - JOBQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

    assign pop_job     = slots_reg[rd_ptr_reg];
    assign stat.empty  = (count_reg == '0);
    assign stat.count  = count_reg;

endmodule

FILE: src/bavg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block average back end
// Divides each queued tile sum by its pixel count with a restoring divider
// and presents the mean in an output register.
// ----------------------------------------------------------------------------
module bavg_back
    import bavg_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  bavg_job_t       job,
    input  bavg_fifo_stat_t q_stat,
    output logic            pop,
    bavg_result_if.source   results
);

    localparam int DIV_CNT_W = $clog2(QUOT_W);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

    state_t               state_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 out_valid_reg;

    logic [QUOT_W-1:0] dq_reg, dq_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg;
    logic [TILE_W-1:0] tcol_reg, trow_reg;
    logic              last_reg, err_reg;

    logic [MEAN_W-1:0] mean_out_reg;
    logic [TILE_W-1:0] tcol_out_reg, trow_out_reg;
    logic              last_out_reg, err_out_reg;

    logic [CNT_W:0] rem_sh, rem_sub;
    logic           qbit, out_free, load_out;

    assign rem_sh   = {rem_reg, dq_reg[QUOT_W-1]};
    assign qbit     = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub  = rem_sh - {1'b0, dvs_reg};
    assign rem_next = qbit ? CNT_W'(rem_sub) : CNT_W'(rem_sh);
    assign dq_next  = {dq_reg[QUOT_W-2:0], qbit};

    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;
    assign out_free = !out_valid_reg || results.ready;
    assign load_out = (state_reg == ST_DONE) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            mean_out_reg  <= '0;
            tcol_out_reg  <= '0;
            trow_out_reg  <= '0;
            last_out_reg  <= 1'b0;
            err_out_reg   <= 1'b0;
        end
        else
        begin
            // A new mean replaces the one the sink takes on the same edge.
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                mean_out_reg  <= dq_reg[MEAN_W-1:0];
                tcol_out_reg  <= tcol_reg;
                trow_out_reg  <= trow_reg;
                last_out_reg  <= last_reg;
                err_out_reg   <= err_reg;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                    if (cnt_reg == DIV_CNT_W'(QUOT_W - 1))
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            dq_reg   <= {job.sum, {FRAC_W{1'b0}}};
            rem_reg  <= '0;
            dvs_reg  <= CNT_W'(job.ncols) * CNT_W'(job.nrows);
            tcol_reg <= job.tile_col;
            trow_reg <= job.tile_row;
            last_reg <= job.last_tile;
            err_reg  <= job.size_error;
        end
        else if (state_reg == ST_DIV)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.mean_value = mean_out_reg;
    assign results.tile_col   = tcol_out_reg;
    assign results.tile_row   = trow_out_reg;
    assign results.last_tile  = last_out_reg;
    assign results.size_error = err_out_reg;

endmodule

FILE: src/block_average_downsampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block average downsampler
// Averages square tiles of a raster-order image and emits one mean per tile
// in raster order of the reduced image.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Payload                                         Accepted when
//   pixels    in    pixel[15:0]                                     valid && ready
//   results   out   mean_value[23:0] tile_col[8:0] tile_row[8:0]    valid && ready
//                   last_tile size_error
//   cfg       in    index[1:0] data[9:0]                            valid && ready
//
// A pixel is taken each cycle while the job queue has room for the tile it may
// close; its accumulator read-modify-write spans two stages with a bypass.
// Each tile holds the back end for a load, 32 divider steps and a hand-off, so
// with a factor of one the job queue fills and pixels wait on the divider.
// A write to a listed register restarts the frame and holds off pixels during
// the size check. Reset needs no clearing pass: each tile's first pixel overwrites.
// ----------------------------------------------------------------------------
module block_average_downsampler
    import bavg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bavg_pixel_if.sink    pixels,
    bavg_result_if.source results,
    bavg_cfg_if.sink      cfg
);

    // Handshake between the front end and the job queue.
    logic            push;
    bavg_job_t       push_job;

    // Handshake between the job queue and the divider back end.
    logic            pop;
    bavg_job_t       pop_job;
    bavg_fifo_stat_t q_stat;

    // The front end owns the registers, raster counters and accumulators.
    // It only takes a pixel when the queue can hold any tile it might finish.
    bavg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixels   (pixels),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    // Finished tiles wait here so the front keeps streaming while the
    // divider is busy or the result channel is stalled.
    bavg_job_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (q_stat)
    );

    // The back end divides sum * 256 by the tile pixel count and keeps the
    // result in an output register until the sink takes it.
    bavg_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .job     (pop_job),
        .q_stat  (q_stat),
        .pop     (pop),
        .results (results)
    );

endmodule

FILE: test/bavg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile mean checker
// Watches the pixel, result and configuration channels of the block average
// downsampler. It keeps its own copy of the accumulator line and raster
// position, predicts the mean of each tile, and compares every result item
// with the oldest prediction.
// ----------------------------------------------------------------------------
module bavg_checker
    import bavg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    bavg_pixel_if  pixels,
    bavg_result_if results,
    bavg_cfg_if    cfg,
    output int     fail_count,
    output int     tiles_pending,
    output int     tiles_checked
);

    typedef struct packed {
        logic [MEAN_W-1:0] mean_value;
        logic [TILE_W-1:0] tile_col;
        logic [TILE_W-1:0] tile_row;
        logic              last_tile;
        logic              size_error;
    } tile_mean_t;

    logic [FACTOR_W-1:0] factor_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [SUM_W-1:0]    column_sums [MAX_WIDTH];
    logic [COL_W-1:0]    at_col;
    logic [COL_W-1:0]    at_row;
    logic [RIT_W-1:0]    at_row_in_tile;
    tile_mean_t          pending_means [$];
    int                  mismatches;
    int                  checked;

    // A setting of zero means one; anything above the limit saturates.
    function automatic int unsigned bound_setting(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic restart_frame();
        at_col         = '0;
        at_row         = '0;
        at_row_in_tile = '0;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("[%0t] tile mismatch on %s: got %0d, expected %0d",
                 $time, what, got, want);
    endtask

    // Adds one pixel into its tile column and queues the mean when the
    // pixel closes a tile.
    task automatic accumulate_pixel(input logic [PIXEL_W-1:0] px);
        int unsigned       f;
        int unsigned       w;
        int unsigned       h;
        int unsigned       col;
        int unsigned       row;
        int unsigned       rit;
        int unsigned       tc;
        int unsigned       idx;
        int unsigned       first_col;
        int unsigned       count;
        logic [QUOT_W-1:0] scaled;
        logic [SUM_W-1:0]  value;
        bit                col_end;
        bit                row_end;
        tile_mean_t        tile;

        f = bound_setting(factor_reg, MAX_FACTOR);
        w = bound_setting(width_reg, MAX_WIDTH);
        h = bound_setting(height_reg, MAX_WIDTH);
        if (at_col >= w || at_row >= h || at_row_in_tile >= f)
            restart_frame();

        col       = at_col;
        row       = at_row;
        rit       = at_row_in_tile;
        tc        = col / f;
        idx       = tc % MAX_WIDTH;
        first_col = tc * f;
        value     = SUM_W'(px & PIXEL_MASK);

        if (rit == 0 && col == first_col)
            column_sums[idx] = value;
        else
            column_sums[idx] = column_sums[idx] + value;

        col_end = (col - first_col == f - 1) || (col == w - 1);
        row_end = (rit == f - 1) || (row == h - 1);
        if (col_end && row_end) begin
            count           = (col - first_col + 1) * (rit + 1);
            scaled          = {column_sums[idx], FRAC_W'(0)};
            tile.mean_value = MEAN_W'(scaled / count);
            tile.tile_col   = TILE_W'(tc);
            tile.tile_row   = TILE_W'(row / f);
            tile.last_tile  = (col == w - 1) && (row == h - 1);
            tile.size_error = (w % f != 0) || (h % f != 0);
            pending_means.insert(pending_means.size(), tile);
        end

        if (col + 1 < w) begin
            at_col = COL_W'(col + 1);
        end else begin
            at_col = '0;
            if (row + 1 < h) begin
                at_row         = COL_W'(row + 1);
                at_row_in_tile = (rit + 1 >= f) ? '0 : RIT_W'(rit + 1);
            end else begin
                at_row         = '0;
                at_row_in_tile = '0;
            end
        end
    endtask

    task automatic check_tile(input tile_mean_t want);
        if (results.mean_value !== want.mean_value)
            report_mismatch("mean_value", results.mean_value, want.mean_value);
        if (results.tile_col !== want.tile_col)
            report_mismatch("tile_col", results.tile_col, want.tile_col);
        if (results.tile_row !== want.tile_row)
            report_mismatch("tile_row", results.tile_row, want.tile_row);
        if (results.last_tile !== want.last_tile)
            report_mismatch("last_tile", results.last_tile, want.last_tile);
        if (results.size_error !== want.size_error)
            report_mismatch("size_error", results.size_error, want.size_error);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            factor_reg = FACTOR_W'(1);
            width_reg  = DIM_W'(MAX_WIDTH);
            height_reg = DIM_W'(MAX_WIDTH);
            for (int i = 0; i < MAX_WIDTH; i++)
                column_sums[i] = '0;
            restart_frame();
            pending_means.delete();
            mismatches = 0;
            checked    = 0;
        end else begin
            // Any write to a listed register restarts the frame.
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_FACTOR:
                    begin
                        factor_reg = cfg.data[FACTOR_W-1:0];
                        restart_frame();
                    end
                    REG_WIDTH:
                    begin
                        width_reg = cfg.data;
                        restart_frame();
                    end
                    REG_HEIGHT:
                    begin
                        height_reg = cfg.data;
                        restart_frame();
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (pixels.valid && pixels.ready)
                accumulate_pixel(pixels.pixel);
            if (results.valid && results.ready) begin
                if (pending_means.size() == 0) begin
                    report_mismatch("result item with no tile waiting",
                                    results.mean_value, 0);
                end else begin
                    check_tile(pending_means.pop_front());
                    checked++;
                end
            end
        end
        fail_count    <= mismatches;
        tiles_pending <= pending_means.size();
        tiles_checked <= checked;
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block average downsampler testbench
// Drives pixel frames and register writes into the downsampler, stalls the
// result side at random and once for a long stretch, and lets the tile mean
// checker compare every result. Directed frames cover the special settings
// and clipped tiles; random frames of random geometry follow.
// ----------------------------------------------------------------------------
module tb_top
    import bavg_pkg::*;
();

    // Index 3 has no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int RANDOM_PIXELS    = 150;
    localparam int QUIET_AFTER      = 110;
    localparam int SETTLE_CYCLES    = 64;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 5000;

    logic clk = 1'b0;
    logic rst_n;

    // Stall rates in percent, set per phase by the stimulus process.
    int pix_gap_pct   = 0;
    int res_stall_pct = 0;

    // The stimulus raises the request; the receiver process marks it done.
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;

    // Register contents as last written, used to size the frames.
    logic [CFG_DATA_W-1:0] cur_width  = CFG_DATA_W'(MAX_WIDTH);
    logic [CFG_DATA_W-1:0] cur_height = CFG_DATA_W'(MAX_WIDTH);

    int pixels_sent     = 0;
    int settings_loaded = 0;
    int idle_cycles     = 0;
    int fail_count;
    int tiles_pending;
    int tiles_checked;

    bavg_pixel_if  pix_if ();
    bavg_result_if res_if ();
    bavg_cfg_if    cfg_if ();

    block_average_downsampler u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_if),
        .results (res_if),
        .cfg     (cfg_if)
    );

    bavg_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixels        (pix_if),
        .results       (res_if),
        .cfg           (cfg_if),
        .fail_count    (fail_count),
        .tiles_pending (tiles_pending),
        .tiles_checked (tiles_checked)
    );

    always #5 clk = ~clk;

    // Pixel values lean toward the extremes so that tile sums hit both ends.
    function automatic logic [PIXEL_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIXEL_W'($urandom);
        endcase
    endfunction

    // A phase either runs with no stalls, light stalls or heavy stalls.
    function automatic int pick_rate();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    function automatic int unsigned effective_size(logic [CFG_DATA_W-1:0] v,
                                                   int unsigned hi);
        if (v == '0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Offers one pixel, sometimes after an idle burst, and returns at the
    // edge where it was accepted. Valid is left high so that back-to-back
    // items stream without a gap.
    task automatic push_pixel(input logic [PIXEL_W-1:0] value);
        if (pix_gap_pct != 0 && $urandom_range(0, 99) < pix_gap_pct) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= value;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // Waits until every predicted tile has come out, then gives the
    // accumulator pipeline time to finish pixels that close no tile.
    // The first edge lets the checker's count catch up with the last pixel.
    task automatic drain();
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (tiles_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_WIDTH:  cur_width  = value;
            REG_HEIGHT: cur_height = value;
            default:
            begin
            end
        endcase
    endtask

    // Writes the selected registers once the block is idle. Bit 3 of the
    // select also writes the unused index with random data.
    task automatic load_geometry(input logic [CFG_DATA_W-1:0] f_data,
                                 input logic [CFG_DATA_W-1:0] w_data,
                                 input logic [CFG_DATA_W-1:0] h_data,
                                 input logic [3:0]            sel);
        drain();
        if (sel[0])
            write_reg(REG_FACTOR, f_data);
        if (sel[1])
            write_reg(REG_WIDTH, w_data);
        if (sel[2])
            write_reg(REG_HEIGHT, h_data);
        if (sel[3])
            write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_if.valid <= 1'b0;
        settings_loaded++;
    endtask

    // Result receiver. It stalls in random bursts at the rate the current
    // phase asks for, and once holds ready low for a long stretch so that
    // the job queue fills and the block has to stall its pixel input.
    initial begin : receiver
        res_if.ready <= 1'b0;
        forever begin
            if (long_hold_req && !long_hold_done) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
            end else if (res_stall_pct != 0 && $urandom_range(0, 99) < res_stall_pct) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end else begin
                res_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog: any accepted item on any channel resets the count. A stuck
    // pipeline or a tile that never comes out ends the run here.
    always @(posedge clk) begin
        if (!rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles < WATCHDOG_LIMIT) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            $display("Timeout: no item moved on any channel for %0d cycles",
                     WATCHDOG_LIMIT);
            $display("FAIL block_average_downsampler");
            $finish;
        end
    end

    initial begin : stimulus
        int                    random_pixels;
        int                    n;
        int unsigned           area;
        logic [CFG_DATA_W-1:0] f_data;
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;
        logic [3:0]            sel;

        random_pixels = 0;
        rst_n        <= 1'b0;
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= REG_FACTOR;
        cfg_if.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- Directed frames -------------------------------------------------

        // A factor of zero behaves as one, so every pixel is a tile of its
        // own and its mean is the pixel itself. The unused index is written
        // as well and must leave the geometry alone.
        load_geometry('0, 10'd2, 10'd2, 4'b1111);
        push_pixel(16'h0000);
        push_pixel(16'hFFFF);
        push_pixel(16'hAAAA);
        push_pixel(16'h5555);

        // Factor 3 written with the upper data bits set, which the register
        // drops. A 4 by 2 image is not a multiple of 3 in either direction,
        // so both tiles carry the size flag and the right one is one column
        // wide. All pixels at full scale give the largest tile sums.
        load_geometry({5'h1F, 5'd3}, 10'd4, 10'd2, 4'b0111);
        repeat (8) push_pixel(16'hFFFF);

        // Factor 2 on a 3 by 3 image: tiles are clipped on the right, at the
        // bottom, and in the bottom-right corner, each with its own divisor.
        load_geometry(10'd2, 10'd3, 10'd3, 4'b0111);
        repeat (9) push_pixel(pick_pixel());

        // The largest factor code saturates at sixteen, and zero width and
        // height act as one: a single pixel makes a whole frame.
        load_geometry(10'd31, '0, '0, 4'b0111);
        push_pixel(16'hFFFF);

        // --- Back pressure -----------------------------------------------------

        // Every pixel closes a tile with a factor of one. The receiver holds
        // off for a long stretch while pixels keep coming, so the job queue
        // fills and the pixel input has to stall.
        load_geometry(10'd1, 10'd10, 10'd4, 4'b0111);
        long_hold_req = 1'b1;
        repeat (40) push_pixel(pick_pixel());

        // --- Saturated sizes ---------------------------------------------------

        // A width code above the limit saturates at 512 columns. With one
        // row, the 513th pixel must open a new frame at tile column zero.
        load_geometry(10'd16, 10'd1023, '0, 4'b0111);
        repeat (513) push_pixel(pick_pixel());

        // A height code just above the limit saturates at 512 rows instead
        // of wrapping to a single row, and the factor code 31 saturates at
        // sixteen: in a one pixel wide column the first tile closes at row 15.
        load_geometry(10'd31, '0, 10'd513, 4'b0111);
        repeat (20) push_pixel(pick_pixel());

        // --- Random frames -------------------------------------------------------

        // Each phase loads a new geometry and mostly sends one or two whole
        // frames, so tiles close in every position. Some phases send a
        // partial frame that the next register write cuts off, and some use
        // huge sizes where only the top-left corner is reached. The final
        // stretch runs without any stalls.
        while (random_pixels < RANDOM_PIXELS) begin
            if (random_pixels >= QUIET_AFTER) begin
                pix_gap_pct   = 0;
                res_stall_pct = 0;
            end else begin
                pix_gap_pct   = pick_rate();
                res_stall_pct = pick_rate();
            end

            case ($urandom_range(0, 9))
                0:       f_data = CFG_DATA_W'($urandom);
                1, 2:    f_data = {5'($urandom), 5'($urandom_range(1, 6))};
                default: f_data = CFG_DATA_W'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0:       w_data = CFG_DATA_W'($urandom);
                1:       w_data = '0;
                default: w_data = CFG_DATA_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 9))
                0:       h_data = CFG_DATA_W'($urandom);
                1:       h_data = '0;
                default: h_data = CFG_DATA_W'($urandom_range(1, 8));
            endcase
            sel = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'b0111;

            load_geometry(f_data, w_data, h_data, sel);
            area = effective_size(cur_width, MAX_WIDTH)
                 * effective_size(cur_height, MAX_WIDTH);
            if (area <= 192 && $urandom_range(0, 4) != 0)
                n = area * $urandom_range(1, 2);
            else
                n = $urandom_range(1, 40);
            // The last phase is cut to the remaining pixel budget.
            if (n > RANDOM_PIXELS - random_pixels)
                n = RANDOM_PIXELS - random_pixels;
            repeat (n) push_pixel(pick_pixel());
            random_pixels += n;
        end

        drain();
        $display("Run summary: %0d pixels under %0d register settings, %0d tile means checked.",
                 pixels_sent, settings_loaded, tiles_checked);
        $display("Covered zero and saturated factors and sizes, clipped tiles, restarts %s",
                 "and a long result stall.");
        if (fail_count == 0 && tiles_pending == 0)
            $display("PASS block_average_downsampler");
        else
            $display("FAIL block_average_downsampler");
        $finish;
    end

endmodule

FILE: files.f
src/bavg_pkg.sv
src/bavg_pixel_if.sv
src/bavg_result_if.sv
src/bavg_cfg_if.sv
src/bavg_front.sv
src/bavg_job_fifo.sv
src/bavg_back.sv
src/block_average_downsampler.sv
test/bavg_checker.sv
test/tb_top.sv
